FILE: hdl/rdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

    // fixed field widths
    localparam int VALUE_BITS    = 32;
    localparam int CHAR_BITS     = 7;
    localparam int RADIX_BITS    = 5;
    localparam int DIGIT_BITS    = 4;
    localparam int RECIP_BITS    = 32;
    localparam int DEF_WORD_BITS = 32;

    // radix limits and reset value
    localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd2;

    // quotient estimate is product >> (SHIFT_BASE + sh)
    localparam int SHIFT_BASE = 32;

    // ascii bases for the two digit ranges
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO   = 7'd48;
    localparam logic [CHAR_BITS-1:0] CHAR_A_BIAS = 7'd87;
    localparam logic [DIGIT_BITS-1:0] DEC_LIMIT  = 4'd10;

    typedef struct packed {
        logic [RECIP_BITS-1:0] mult;
        logic [1:0]            sh;
    } t_recip;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic fix;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic quot_done;
        logic rd_at_zero;
    } t_dp_stat;

    // floor(2^(31+l) / d) with l = ceil(log2 d), always fits 32 bits
    function automatic t_recip recip_of(input logic [RADIX_BITS-1:0] d);
        t_recip r;
        unique case (d)
            5'd2:    r = '{mult: 32'h8000_0000, sh: 2'd0};
            5'd3:    r = '{mult: 32'hAAAA_AAAA, sh: 2'd1};
            5'd4:    r = '{mult: 32'h8000_0000, sh: 2'd1};
            5'd5:    r = '{mult: 32'hCCCC_CCCC, sh: 2'd2};
            5'd6:    r = '{mult: 32'hAAAA_AAAA, sh: 2'd2};
            5'd7:    r = '{mult: 32'h9249_2492, sh: 2'd2};
            5'd8:    r = '{mult: 32'h8000_0000, sh: 2'd2};
            5'd9:    r = '{mult: 32'hE38E_38E3, sh: 2'd3};
            5'd10:   r = '{mult: 32'hCCCC_CCCC, sh: 2'd3};
            5'd11:   r = '{mult: 32'hBA2E_8BA2, sh: 2'd3};
            5'd12:   r = '{mult: 32'hAAAA_AAAA, sh: 2'd3};
            5'd13:   r = '{mult: 32'h9D89_D89D, sh: 2'd3};
            5'd14:   r = '{mult: 32'h9249_2492, sh: 2'd3};
            5'd15:   r = '{mult: 32'h8888_8888, sh: 2'd3};
            5'd16:   r = '{mult: 32'h8000_0000, sh: 2'd3};
            default: r = '{mult: 32'h8000_0000, sh: 2'd0};
        endcase
        return r;
    endfunction

    // lower-case ascii glyph of one digit
    function automatic logic [CHAR_BITS-1:0] glyph_of(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d < DEC_LIMIT) begin
            c = CHAR_ZERO + CHAR_BITS'(d);
        end else begin
            c = CHAR_A_BIAS + CHAR_BITS'(d);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/rdc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rdc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/rdc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rdc_datapath #(
    parameter int WORD_BITS = rdc_pkg::DEF_WORD_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [rdc_pkg::RADIX_BITS-1:0]      i_cfg_wdata,
    input  wire logic [rdc_pkg::VALUE_BITS-1:0]      i_value,
    input  wire rdc_pkg::t_dp_cmd                    i_cmd,
    output rdc_pkg::t_dp_stat                        o_stat,
    output logic                                     o_digit_strobe,
    output logic      [rdc_pkg::CHAR_BITS-1:0]       o_digit_char,
    output logic                                     o_last_digit
);

    import rdc_pkg::*;

    localparam int QW = (WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS;
    localparam int AW = $clog2(WORD_BITS);
    localparam int CW = $clog2(WORD_BITS + 1);
    localparam int PW = QW + RECIP_BITS;
    localparam int DW = QW + RADIX_BITS;

    logic [RADIX_BITS-1:0] r_radix;
    logic [QW-1:0]         r_quot;
    logic [PW-1:0]         r_prod;
    logic [CW-1:0]         r_cnt;
    logic [AW-1:0]         r_rd_ptr;
    logic                  r_out_vld;
    logic                  r_out_last;

    t_recip                recip;
    logic [QW-1:0]         qest;
    logic [DW-1:0]         qd;
    logic [DW-1:0]         diff;
    logic [RADIX_BITS-1:0] rem_raw;
    logic                  corr;
    logic [RADIX_BITS-1:0] rem_fix;
    logic [QW-1:0]         n_quot;
    logic [DIGIT_BITS-1:0] rd_digit;

    assign recip = recip_of(r_radix);

    // quotient estimate is exact or one low
    always_comb begin
        case (recip.sh)
            2'd0:    qest = QW'(r_prod >> SHIFT_BASE);
            2'd1:    qest = QW'(r_prod >> (SHIFT_BASE + 1));
            2'd2:    qest = QW'(r_prod >> (SHIFT_BASE + 2));
            default: qest = QW'(r_prod >> (SHIFT_BASE + 3));
        endcase
    end

    assign qd      = DW'(qest) * DW'(r_radix);
    assign diff    = DW'(r_quot) - qd;
    assign rem_raw = diff[RADIX_BITS-1:0];
    assign corr    = (rem_raw >= r_radix);
    assign rem_fix = corr ? (rem_raw - r_radix) : rem_raw;
    assign n_quot  = qest + QW'(corr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix    <= RADIX_RESET;
            r_quot     <= '0;
            r_cnt      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_wdata < RADIX_MIN) begin
                    r_radix <= RADIX_MIN;
                end else if (i_cfg_wdata > RADIX_MAX) begin
                    r_radix <= RADIX_MAX;
                end else begin
                    r_radix <= i_cfg_wdata;
                end
            end
            if (i_cmd.load) begin
                r_quot <= i_value[QW-1:0];
                r_cnt  <= '0;
            end else if (i_cmd.fix) begin
                r_quot <= n_quot;
                r_cnt  <= r_cnt + CW'(1);
            end
            r_out_vld <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PW'(r_quot) * PW'(recip.mult);
        end
        // the last digit stored is the first one read back
        if (i_cmd.fix) begin
            r_rd_ptr <= r_cnt[AW-1:0];
        end else if (i_cmd.emit) begin
            r_rd_ptr <= r_rd_ptr - AW'(1);
        end
        if (i_cmd.emit) begin
            r_out_last <= (r_rd_ptr == '0);
        end
    end

    rdc_ram #(
        .WIDTH (DIGIT_BITS),
        .DEPTH (WORD_BITS)
    ) u_digit_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fix),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (rem_fix[DIGIT_BITS-1:0]),
        .i_re    (i_cmd.emit),
        .i_raddr (r_rd_ptr),
        .o_rdata (rd_digit)
    );

    assign o_stat.quot_done  = (n_quot == '0);
    assign o_stat.rd_at_zero = (r_rd_ptr == '0);

    assign o_digit_strobe = r_out_vld;
    assign o_digit_char   = glyph_of(rd_digit);
    assign o_last_digit   = r_out_last;

endmodule

`default_nettype wire

FILE: hdl/rdc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rdc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire rdc_pkg::t_dp_stat  i_stat,
    output rdc_pkg::t_dp_cmd        o_cmd,
    output logic                    o_busy
);

    import rdc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_FIX,
        S_EMIT,
        S_LAST
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_FIX;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = i_stat.quot_done ? S_EMIT : S_MUL;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.rd_at_zero) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

FILE: hdl/radix_digit_converter.sv
`timescale 1ns / 1ps
`default_nettype none

// Converts an unsigned number to its digits in radix 2..16 and sends them out most
// significant first as lower-case ascii ('0'-'9', 'a'-'f'), one per cycle with
// o_digit_strobe, the final (least significant) digit marked by o_last_digit. A zero
// value gives the single digit '0'. The receiver cannot stall: every strobed digit must
// be taken in its cycle. A number is taken when start is high and busy is low; busy
// then stays high until the final digit has been sent, so the next number can only be
// taken after that. Each digit costs a division (a multiply by the radix reciprocal,
// then a correct-and-store step) and a read-out from the digit store, whose read is
// registered, as is the strobe that goes with it. The radix register takes writes on
// i_cfg_we, clamped to 2..16, and resets to 2; write it only while busy is low. Only
// the low WORD_BITS bits of i_value are converted.
module radix_digit_converter #(
    parameter int WORD_BITS = rdc_pkg::DEF_WORD_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [rdc_pkg::VALUE_BITS-1:0]  i_value,
    input  wire logic                            i_cfg_we,
    input  wire logic [rdc_pkg::RADIX_BITS-1:0]  i_cfg_wdata,
    output logic                                 o_digit_strobe,
    output logic      [rdc_pkg::CHAR_BITS-1:0]   o_digit_char,
    output logic                                 o_last_digit
);

    import rdc_pkg::*;

    // command and status between sequencer and datapath
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: load, then multiply/fix per digit, then read out
    rdc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    // radix register, reciprocal divider, digit store and glyph lookup
    rdc_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_value        (i_value),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_digit_strobe (o_digit_strobe),
        .o_digit_char   (o_digit_char),
        .o_last_digit   (o_last_digit)
    );

`ifndef SYNTHESIS
    // digits only come out while a conversion is in flight
    a_strobe_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digit_strobe |-> busy)
        else $error("digit strobe while not busy");

    // the final digit ends the conversion
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_digit_strobe && o_last_digit) |=> !busy)
        else $error("busy still high after final digit");

    // a transfer in starts division, no digit can follow right away
    a_start_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_digit_strobe))
        else $error("bad response to accepted start");
`endif

endmodule

`default_nettype wire
